// ===== src/bdec_pkg.sv =====
`default_nettype none
package bdec_pkg;

	// parser modes
	localparam logic [2:0] MODE_IDLE       = 3'd0;
	localparam logic [2:0] MODE_INT_START  = 3'd1;
	localparam logic [2:0] MODE_INT_DIGITS = 3'd2;
	localparam logic [2:0] MODE_STR_LEN    = 3'd3;
	localparam logic [2:0] MODE_STR_BODY   = 3'd4;
	localparam logic [2:0] MODE_VALUE      = 3'd5;
	localparam logic [2:0] MODE_DONE       = 3'd6;

	// event kinds
	localparam logic [2:0] EV_INT   = 3'd0;
	localparam logic [2:0] EV_HDR   = 3'd1;
	localparam logic [2:0] EV_BYTE  = 3'd2;
	localparam logic [2:0] EV_LOPEN = 3'd3;
	localparam logic [2:0] EV_DOPEN = 3'd4;
	localparam logic [2:0] EV_CLOSE = 3'd5;
	localparam logic [2:0] EV_ERR   = 3'd6;

	// error codes
	localparam logic [2:0] ERR_EARLY_END = 3'd0;
	localparam logic [2:0] ERR_BAD_TYPE  = 3'd1;
	localparam logic [2:0] ERR_NON_DIGIT = 3'd2;
	localparam logic [2:0] ERR_OVERFLOW  = 3'd3;
	localparam logic [2:0] ERR_TOO_DEEP  = 3'd4;

	// syntax characters
	localparam logic [7:0] CH_INT   = 8'h69;
	localparam logic [7:0] CH_LIST  = 8'h6C;
	localparam logic [7:0] CH_DICT  = 8'h64;
	localparam logic [7:0] CH_END   = 8'h65;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// stack entry bits
	localparam logic [1:0] ENT_LIST     = 2'b00;
	localparam logic [1:0] ENT_DICT_KEY = 2'b11;
	localparam logic [1:0] ENT_KEY_BIT  = 2'b10;

	// magnitude limits of a 64-bit integer
	localparam logic [63:0] INT_LIM_POS = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] INT_LIM_NEG = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic [2:0]  kind;
		logic [63:0] ival;
		logic [31:0] len;
		logic [7:0]  data;
		logic        key;
		logic        send;
		logic [2:0]  err;
		logic [5:0]  level;
		logic        last;
	} res_t;

	function automatic res_t mk_err(input logic [2:0] code, input logic [5:0] level);
		res_t r;
		r = '0;
		r.kind = EV_ERR;
		r.err = code;
		r.level = level;
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== src/bencode_stream_decoder.sv =====
// channel   | signals                                   | direction
// input     | in_valid, in_stall, in_byte, end_of_data  | byte request in
// output    | out_valid, out_stall, event_kind .. run_last | zero to two events per request out
//
// one byte per clock while in_stall is low; a byte that yields an event plus an early-end error
// gives two results, the extra result is absorbed by the result queue
// an accepted byte is held in the input register until the parser takes it; its events are
// then offered from a four-entry result queue
// arst_n clears the parser state and the queue; the container stack memory is not cleared
// input stalls while a byte is held and the result queue holds more than two entries
`default_nettype none
module bencode_stream_decoder #(
	parameter int MAX_DEPTH   = 32,
	parameter int LENGTH_BITS = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         in_byte,
	input  wire logic               end_of_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [2:0]              event_kind,
	output logic signed [63:0]      int_value,
	output logic [31:0]             string_length,
	output logic [7:0]              out_byte,
	output logic                    is_key,
	output logic                    string_end,
	output logic [2:0]              error_code,
	output logic [5:0]              nest_level,
	output logic                    run_last
);

	localparam int DW = $clog2(MAX_DEPTH + 1);
	localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eod_s1;

	// parser state
	logic [2:0]             mode_q;
	logic [63:0]            acc_q;
	logic                   neg_q;
	logic [LENGTH_BITS-1:0] rem_q;
	logic [DW-1:0]          depth_q;
	logic                   digit_q;
	logic [1:0]             top_q;
	logic [1:0]             below_q;
	logic [1:0]             stack_mem [0:MAX_DEPTH-1];

	// result queue
	bdec_pkg::res_t fifo_q [0:3];
	logic [1:0]     rd_ptr_q;
	logic [1:0]     wr_ptr_q;
	logic [2:0]     cnt_q;

	logic adv;
	logic room;
	logic pop;

	// next state
	logic [2:0]             mode_n;
	logic [63:0]            acc_n;
	logic                   neg_n;
	logic [LENGTH_BITS-1:0] rem_n;
	logic [DW-1:0]          depth_n;
	logic                   digit_n;
	logic [1:0]             top_n;
	logic                   push;
	logic [AW-1:0]          wr_addr;
	logic [AW-1:0]          rd_addr;
	logic [DW-1:0]          rd_depth;

	bdec_pkg::res_t r0;
	bdec_pkg::res_t r1;
	logic [1:0]     n_res;

	// decode helpers
	logic                   top_dict;
	logic                   wants_key;
	logic                   is_dig;
	logic [3:0]             dig;
	logic [67:0]            prod;
	logic                   ok_int;
	logic                   ok_len;
	logic [2:0]             fin_mode;
	logic [1:0]             fin_top;
	logic [DW-1:0]          cls_depth;
	logic [2:0]             cls_mode;
	logic [1:0]             cls_top;
	logic [LENGTH_BITS-1:0] rem_dec;

	assign room = (cnt_q <= 3'd2);
	assign adv = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign pop = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
			eod_s1 <= end_of_data;
		end
	end

	always_comb begin
		top_dict = (depth_q != '0) && top_q[0];
		wants_key = top_dict && top_q[1];
		is_dig = (byte_s1 >= bdec_pkg::CH_ZERO) && (byte_s1 <= bdec_pkg::CH_NINE);
		dig = 4'(byte_s1 - bdec_pkg::CH_ZERO);
		// acc * 10 + digit, checked against the limit instead of dividing it
		prod = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {64'd0, dig};
		ok_int = prod <= {4'd0, (neg_q ? bdec_pkg::INT_LIM_NEG : bdec_pkg::INT_LIM_POS)};
		ok_len = (prod >> LENGTH_BITS) == 68'd0;
		fin_mode = (depth_q == '0) ? bdec_pkg::MODE_DONE : bdec_pkg::MODE_VALUE;
		fin_top = top_q[0] ? (top_q ^ bdec_pkg::ENT_KEY_BIT) : top_q;
		cls_depth = depth_q - DW'(1);
		cls_mode = (cls_depth == '0) ? bdec_pkg::MODE_DONE : bdec_pkg::MODE_VALUE;
		cls_top = below_q[0] ? (below_q ^ bdec_pkg::ENT_KEY_BIT) : below_q;
		rem_dec = rem_q - LENGTH_BITS'(1);

		mode_n = mode_q;
		acc_n = acc_q;
		neg_n = neg_q;
		rem_n = rem_q;
		depth_n = depth_q;
		digit_n = digit_q;
		top_n = top_q;
		push = 1'b0;
		r0 = '0;
		r1 = '0;
		r0.level = 6'(depth_q);
		n_res = 2'd0;

		case (mode_q)
			bdec_pkg::MODE_IDLE, bdec_pkg::MODE_VALUE: begin
				if (mode_q == bdec_pkg::MODE_VALUE && depth_q != '0 &&
						byte_s1 == bdec_pkg::CH_END && (!top_dict || wants_key)) begin
					depth_n = cls_depth;
					top_n = cls_top;
					mode_n = cls_mode;
					r0.kind = bdec_pkg::EV_CLOSE;
					r0.level = 6'(cls_depth);
					n_res = 2'd1;
				end else if (is_dig) begin
					acc_n = {60'd0, dig};
					mode_n = bdec_pkg::MODE_STR_LEN;
				end else if (wants_key) begin
					r0 = bdec_pkg::mk_err(bdec_pkg::ERR_BAD_TYPE, 6'(depth_q));
					mode_n = bdec_pkg::MODE_DONE;
					n_res = 2'd1;
				end else if (byte_s1 == bdec_pkg::CH_INT) begin
					acc_n = '0;
					neg_n = 1'b0;
					digit_n = 1'b0;
					mode_n = bdec_pkg::MODE_INT_START;
				end else if (byte_s1 == bdec_pkg::CH_LIST || byte_s1 == bdec_pkg::CH_DICT) begin
					if (depth_q >= DW'(MAX_DEPTH)) begin
						r0 = bdec_pkg::mk_err(bdec_pkg::ERR_TOO_DEEP, 6'(depth_q));
						mode_n = bdec_pkg::MODE_DONE;
					end else begin
						// old top goes to memory, new entry lives in top_q
						push = (depth_q != '0);
						depth_n = depth_q + DW'(1);
						top_n = (byte_s1 == bdec_pkg::CH_DICT) ?
							bdec_pkg::ENT_DICT_KEY : bdec_pkg::ENT_LIST;
						r0.kind = (byte_s1 == bdec_pkg::CH_DICT) ?
							bdec_pkg::EV_DOPEN : bdec_pkg::EV_LOPEN;
						r0.level = 6'(depth_q + DW'(1));
						mode_n = bdec_pkg::MODE_VALUE;
					end
					n_res = 2'd1;
				end else begin
					r0 = bdec_pkg::mk_err(bdec_pkg::ERR_BAD_TYPE, 6'(depth_q));
					mode_n = bdec_pkg::MODE_DONE;
					n_res = 2'd1;
				end
			end
			bdec_pkg::MODE_INT_START, bdec_pkg::MODE_INT_DIGITS: begin
				if (mode_q == bdec_pkg::MODE_INT_START && byte_s1 == bdec_pkg::CH_MINUS) begin
					neg_n = 1'b1;
					mode_n = bdec_pkg::MODE_INT_DIGITS;
				end else if (is_dig) begin
					if (!ok_int) begin
						r0 = bdec_pkg::mk_err(bdec_pkg::ERR_OVERFLOW, 6'(depth_q));
						mode_n = bdec_pkg::MODE_DONE;
						n_res = 2'd1;
					end else begin
						acc_n = prod[63:0];
						digit_n = 1'b1;
						mode_n = bdec_pkg::MODE_INT_DIGITS;
					end
				end else if (byte_s1 == bdec_pkg::CH_END && digit_q) begin
					r0.kind = bdec_pkg::EV_INT;
					r0.ival = neg_q ? (64'd0 - acc_q) : acc_q;
					mode_n = fin_mode;
					top_n = fin_top;
					n_res = 2'd1;
				end else begin
					r0 = bdec_pkg::mk_err(bdec_pkg::ERR_NON_DIGIT, 6'(depth_q));
					mode_n = bdec_pkg::MODE_DONE;
					n_res = 2'd1;
				end
			end
			bdec_pkg::MODE_STR_LEN: begin
				if (is_dig) begin
					if (!ok_len) begin
						r0 = bdec_pkg::mk_err(bdec_pkg::ERR_OVERFLOW, 6'(depth_q));
						mode_n = bdec_pkg::MODE_DONE;
						n_res = 2'd1;
					end else begin
						acc_n = prod[63:0];
					end
				end else if (byte_s1 == bdec_pkg::CH_COLON) begin
					rem_n = acc_q[LENGTH_BITS-1:0];
					r0.kind = bdec_pkg::EV_HDR;
					r0.len = acc_q[31:0];
					r0.key = wants_key;
					r0.send = (acc_q == 64'd0);
					if (acc_q == 64'd0) begin
						mode_n = fin_mode;
						top_n = fin_top;
					end else begin
						mode_n = bdec_pkg::MODE_STR_BODY;
					end
					n_res = 2'd1;
				end else begin
					r0 = bdec_pkg::mk_err(bdec_pkg::ERR_NON_DIGIT, 6'(depth_q));
					mode_n = bdec_pkg::MODE_DONE;
					n_res = 2'd1;
				end
			end
			bdec_pkg::MODE_STR_BODY: begin
				rem_n = rem_dec;
				r0.kind = bdec_pkg::EV_BYTE;
				r0.data = byte_s1;
				r0.key = wants_key;
				r0.send = (rem_dec == '0);
				if (rem_dec == '0) begin
					mode_n = fin_mode;
					top_n = fin_top;
				end
				n_res = 2'd1;
			end
			default: begin
			end
		endcase

		if (eod_s1) begin
			if (mode_n != bdec_pkg::MODE_DONE) begin
				if (n_res == 2'd0) begin
					r0 = bdec_pkg::mk_err(bdec_pkg::ERR_EARLY_END, 6'(depth_n));
					n_res = 2'd1;
				end else begin
					r1 = bdec_pkg::mk_err(bdec_pkg::ERR_EARLY_END, 6'(depth_n));
					n_res = 2'd2;
				end
			end
			mode_n = bdec_pkg::MODE_IDLE;
			acc_n = '0;
			neg_n = 1'b0;
			rem_n = '0;
			depth_n = '0;
			digit_n = 1'b0;
		end

		r0.last = (n_res == 2'd1);
		r1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= bdec_pkg::MODE_IDLE;
			acc_q <= '0;
			neg_q <= 1'b0;
			rem_q <= '0;
			depth_q <= '0;
			digit_q <= 1'b0;
			top_q <= '0;
		end else if (adv) begin
			mode_q <= mode_n;
			acc_q <= acc_n;
			neg_q <= neg_n;
			rem_q <= rem_n;
			depth_q <= depth_n;
			digit_q <= digit_n;
			top_q <= top_n;
		end
	end

	// stack below the top entry; below_q always holds entry depth-2
	assign wr_addr = AW'(depth_q - DW'(1));
	assign rd_depth = adv ? depth_n : depth_q;
	assign rd_addr = AW'(rd_depth - DW'(2));

	always_ff @(posedge clk) begin
		if (adv && push) begin
			stack_mem[wr_addr] <= top_q;
		end
		if (adv && push && wr_addr == rd_addr) begin
			below_q <= top_q;
		end else begin
			below_q <= stack_mem[rd_addr];
		end
	end

	// result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			if (adv) begin
				wr_ptr_q <= wr_ptr_q + n_res;
			end
			cnt_q <= cnt_q + (adv ? {1'b0, n_res} : 3'd0) - {2'd0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (adv && n_res != 2'd0) begin
			fifo_q[wr_ptr_q] <= r0;
		end
		if (adv && n_res == 2'd2) begin
			fifo_q[wr_ptr_q + 2'd1] <= r1;
		end
	end

	assign out_valid = (cnt_q != 3'd0);
	assign event_kind = fifo_q[rd_ptr_q].kind;
	assign int_value = $signed(fifo_q[rd_ptr_q].ival);
	assign string_length = fifo_q[rd_ptr_q].len;
	assign out_byte = fifo_q[rd_ptr_q].data;
	assign is_key = fifo_q[rd_ptr_q].key;
	assign string_end = fifo_q[rd_ptr_q].send;
	assign error_code = fifo_q[rd_ptr_q].err;
	assign nest_level = fifo_q[rd_ptr_q].level;
	assign run_last = fifo_q[rd_ptr_q].last;

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(MAX_DEPTH))
		else $error("nesting depth beyond limit");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("result queue overrun");

	a_eod_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && eod_s1) |=> (mode_q == bdec_pkg::MODE_IDLE && depth_q == '0))
		else $error("parser not back to idle after end of data");

	a_last_on_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && n_res == 2'd2) |-> (r1.kind == bdec_pkg::EV_ERR && !r0.last))
		else $error("second result of a byte is not the closing error");

endmodule
`default_nettype wire

// ===== sim/tb_bencode_stream_decoder.sv =====
`timescale 1ns / 100ps
module tb_bencode_stream_decoder;

	localparam int DEPTH_LIMIT = 32;
	localparam int LEN_BITS    = 32;
	localparam logic [63:0] LEN_MAX = (64'd1 << LEN_BITS) - 64'd1;

	typedef struct {
		logic [7:0] data;
		bit         eod;
		bit         drain;
	} byte_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] in_byte = 8'd0;
	logic end_of_data = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] event_kind;
	logic signed [63:0] int_value;
	logic [31:0] string_length;
	logic [7:0] out_byte;
	logic is_key;
	logic string_end;
	logic [2:0] error_code;
	logic [5:0] nest_level;
	logic run_last;

	byte_req_t pending_reqs[$];
	logic [7:0] msg_bytes[$];
	bdec_pkg::res_t want_events[$];
	bdec_pkg::res_t step_events[$];

	// parser shadow state
	logic [2:0] p_mode;
	logic [63:0] p_acc;
	bit p_neg;
	logic [63:0] p_rem;
	int p_depth;
	logic [1:0] p_stack[DEPTH_LIMIT];
	bit p_digit;

	int err_count = 0;
	int sent_count = 0;
	int events_checked = 0;
	int msg_count = 0;
	int drain_count = 0;
	int real_bytes = 0;
	logic calm;

	// one stretch of the run with no random breaks on either side
	assign calm = sent_count >= 500 && sent_count < 800;

	bencode_stream_decoder #(
		.MAX_DEPTH(DEPTH_LIMIT),
		.LENGTH_BITS(LEN_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.end_of_data(end_of_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_kind(event_kind),
		.int_value(int_value),
		.string_length(string_length),
		.out_byte(out_byte),
		.is_key(is_key),
		.string_end(string_end),
		.error_code(error_code),
		.nest_level(nest_level),
		.run_last(run_last)
	);

	always #5 clk = ~clk;

	function automatic bit take_break();
		return !calm && ($urandom_range(99) < 7);
	endfunction

	function automatic void clear_parser();
		p_mode = bdec_pkg::MODE_IDLE;
		p_acc = 64'd0;
		p_neg = 1'b0;
		p_rem = 64'd0;
		p_depth = 0;
		p_digit = 1'b0;
	endfunction

	function automatic bit top_dict();
		return p_depth > 0 && p_stack[p_depth - 1][0];
	endfunction

	function automatic bit key_due();
		return top_dict() && p_stack[p_depth - 1][1];
	endfunction

	function automatic void item_done();
		if (p_depth == 0) begin
			p_mode = bdec_pkg::MODE_DONE;
		end else begin
			if (top_dict())
				p_stack[p_depth - 1][1] = ~p_stack[p_depth - 1][1];
			p_mode = bdec_pkg::MODE_VALUE;
		end
	endfunction

	function automatic void note(logic [2:0] kind, logic [63:0] ival, logic [31:0] len,
			logic [7:0] data, bit key, bit send, logic [2:0] code);
		bdec_pkg::res_t r;
		r = '0;
		r.kind = kind;
		r.ival = ival;
		r.len = len;
		r.data = data;
		r.key = key;
		r.send = send;
		r.err = code;
		r.level = 6'(p_depth);
		step_events.insert(step_events.size(), r);
	endfunction

	function automatic void abort_parse(logic [2:0] code);
		note(bdec_pkg::EV_ERR, 64'd0, 32'd0, 8'd0, 1'b0, 1'b0, code);
		p_mode = bdec_pkg::MODE_DONE;
	endfunction

	// false when the next digit would push the value past the limit
	function automatic bit acc_digit(logic [7:0] b, logic [63:0] lim);
		logic [63:0] d;
		d = {56'd0, 8'(b - bdec_pkg::CH_ZERO)};
		if (p_acc > (lim - d) / 64'd10)
			return 1'b0;
		p_acc = p_acc * 64'd10 + d;
		return 1'b1;
	endfunction

	function automatic void decode_byte(logic [7:0] b, bit eod);
		bit dig;
		bit key;
		dig = b >= bdec_pkg::CH_ZERO && b <= bdec_pkg::CH_NINE;
		step_events.delete();
		case (p_mode)
			bdec_pkg::MODE_IDLE, bdec_pkg::MODE_VALUE: begin
				if (p_mode == bdec_pkg::MODE_VALUE && p_depth > 0 && b == bdec_pkg::CH_END &&
						(!top_dict() || key_due())) begin
					p_depth--;
					note(bdec_pkg::EV_CLOSE, 64'd0, 32'd0, 8'd0, 1'b0, 1'b0,
						bdec_pkg::ERR_EARLY_END);
					item_done();
				end else if (dig) begin
					p_acc = {56'd0, 8'(b - bdec_pkg::CH_ZERO)};
					p_mode = bdec_pkg::MODE_STR_LEN;
				end else if (key_due()) begin
					abort_parse(bdec_pkg::ERR_BAD_TYPE);
				end else if (b == bdec_pkg::CH_INT) begin
					p_acc = 64'd0;
					p_neg = 1'b0;
					p_digit = 1'b0;
					p_mode = bdec_pkg::MODE_INT_START;
				end else if (b == bdec_pkg::CH_LIST || b == bdec_pkg::CH_DICT) begin
					if (p_depth >= DEPTH_LIMIT) begin
						abort_parse(bdec_pkg::ERR_TOO_DEEP);
					end else begin
						p_stack[p_depth] = (b == bdec_pkg::CH_DICT) ?
							bdec_pkg::ENT_DICT_KEY : bdec_pkg::ENT_LIST;
						p_depth++;
						note((b == bdec_pkg::CH_DICT) ? bdec_pkg::EV_DOPEN : bdec_pkg::EV_LOPEN,
							64'd0, 32'd0, 8'd0, 1'b0, 1'b0, bdec_pkg::ERR_EARLY_END);
						p_mode = bdec_pkg::MODE_VALUE;
					end
				end else begin
					abort_parse(bdec_pkg::ERR_BAD_TYPE);
				end
			end
			bdec_pkg::MODE_INT_START, bdec_pkg::MODE_INT_DIGITS: begin
				if (p_mode == bdec_pkg::MODE_INT_START && b == bdec_pkg::CH_MINUS) begin
					p_neg = 1'b1;
					p_mode = bdec_pkg::MODE_INT_DIGITS;
				end else if (dig) begin
					if (!acc_digit(b, p_neg ? bdec_pkg::INT_LIM_NEG : bdec_pkg::INT_LIM_POS)) begin
						abort_parse(bdec_pkg::ERR_OVERFLOW);
					end else begin
						p_digit = 1'b1;
						p_mode = bdec_pkg::MODE_INT_DIGITS;
					end
				end else if (b == bdec_pkg::CH_END && p_digit) begin
					note(bdec_pkg::EV_INT, p_neg ? (64'd0 - p_acc) : p_acc, 32'd0, 8'd0,
						1'b0, 1'b0, bdec_pkg::ERR_EARLY_END);
					item_done();
				end else begin
					abort_parse(bdec_pkg::ERR_NON_DIGIT);
				end
			end
			bdec_pkg::MODE_STR_LEN: begin
				if (dig) begin
					if (!acc_digit(b, LEN_MAX))
						abort_parse(bdec_pkg::ERR_OVERFLOW);
				end else if (b == bdec_pkg::CH_COLON) begin
					key = key_due();
					p_rem = p_acc;
					note(bdec_pkg::EV_HDR, 64'd0, p_rem[31:0], 8'd0, key, p_rem == 64'd0,
						bdec_pkg::ERR_EARLY_END);
					if (p_rem == 64'd0)
						item_done();
					else
						p_mode = bdec_pkg::MODE_STR_BODY;
				end else begin
					abort_parse(bdec_pkg::ERR_NON_DIGIT);
				end
			end
			bdec_pkg::MODE_STR_BODY: begin
				key = key_due();
				p_rem = p_rem - 64'd1;
				note(bdec_pkg::EV_BYTE, 64'd0, 32'd0, b, key, p_rem == 64'd0,
					bdec_pkg::ERR_EARLY_END);
				if (p_rem == 64'd0)
					item_done();
			end
			default: ;
		endcase
		if (eod) begin
			if (p_mode != bdec_pkg::MODE_DONE)
				abort_parse(bdec_pkg::ERR_EARLY_END);
			clear_parser();
		end
		if (step_events.size() > 0)
			step_events[step_events.size() - 1].last = 1'b1;
		foreach (step_events[i])
			want_events.insert(want_events.size(), step_events[i]);
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			err_count++;
		end
	endfunction

	task automatic put_digits(input logic [63:0] value);
		logic [7:0] digs[$];
		logic [63:0] v;
		v = value;
		do begin
			digs.push_front(bdec_pkg::CH_ZERO + 8'(v % 64'd10));
			v = v / 64'd10;
		end while (v != 64'd0);
		foreach (digs[i])
			msg_bytes.insert(msg_bytes.size(), digs[i]);
	endtask

	task automatic put_int();
		logic [63:0] mag;
		bit neg;
		int pick;
		neg = $urandom_range(1);
		pick = $urandom_range(9);
		msg_bytes.insert(msg_bytes.size(), bdec_pkg::CH_INT);
		if (neg)
			msg_bytes.insert(msg_bytes.size(), bdec_pkg::CH_MINUS);
		case (pick)
			0: mag = neg ? bdec_pkg::INT_LIM_NEG : bdec_pkg::INT_LIM_POS;
			1: mag = (neg ? bdec_pkg::INT_LIM_NEG : bdec_pkg::INT_LIM_POS) + 64'd1 +
				64'($urandom_range(3));
			2: mag = {$urandom, $urandom} >> $urandom_range(63);
			default: mag = 64'($urandom_range(1000));
		endcase
		// integer with no digits at all
		if (pick != 3) begin
			if ($urandom_range(9) == 0)
				msg_bytes.insert(msg_bytes.size(), bdec_pkg::CH_ZERO);
			put_digits(mag);
		end
		msg_bytes.insert(msg_bytes.size(), bdec_pkg::CH_END);
	endtask

	// huge strings send two bytes of a large length, some past 32 bits
	task automatic put_str(input bit huge);
		logic [63:0] len;
		if (huge) begin
			case ($urandom_range(3))
				0: len = 64'hFFFF_FFFF;
				1: len = 64'h1_0000_0000;
				2: len = {32'd0, $urandom};
				default: len = 64'd123456789012;
			endcase
		end else begin
			len = ($urandom_range(7) == 0) ? 64'($urandom_range(24)) : 64'($urandom_range(4));
		end
		if ($urandom_range(11) == 0)
			msg_bytes.insert(msg_bytes.size(), bdec_pkg::CH_ZERO);
		put_digits(len);
		msg_bytes.insert(msg_bytes.size(), bdec_pkg::CH_COLON);
		repeat (huge ? 64'd2 : len)
			msg_bytes.insert(msg_bytes.size(), 8'($urandom_range(255)));
	endtask

	task automatic send_msg(input bit drain, input int counted);
		byte_req_t req;
		foreach (msg_bytes[i]) begin
			req.data = msg_bytes[i];
			req.eod = (i == msg_bytes.size() - 1);
			req.drain = drain && (i == 0);
			pending_reqs.insert(pending_reqs.size(), req);
		end
		msg_bytes.delete();
		real_bytes += counted;
		msg_count++;
		if (drain)
			drain_count++;
	endtask

	// request driver, predicts each byte as it is accepted
	always @(posedge clk or negedge arst_n) begin : drive
		byte_req_t req;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte <= 8'd0;
			end_of_data <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				decode_byte(in_byte, end_of_data);
				sent_count++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_reqs.size() > 0 && !take_break() &&
						!(pending_reqs[0].drain && want_events.size() > 0)) begin
					req = pending_reqs.pop_front();
					in_valid <= 1'b1;
					in_byte <= req.data;
					end_of_data <= req.eod;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// event monitor
	always @(posedge clk or negedge arst_n) begin : watch
		bdec_pkg::res_t due;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (want_events.size() == 0) begin
					$error("event of kind %0d arrived with no event expected", event_kind);
					err_count++;
				end else begin
					due = want_events.pop_front();
					check_field("event_kind", due.kind, event_kind);
					check_field("int_value", due.ival, int_value);
					check_field("string_length", due.len, string_length);
					check_field("out_byte", due.data, out_byte);
					check_field("is_key", due.key, is_key);
					check_field("string_end", due.send, string_end);
					check_field("error_code", due.err, error_code);
					check_field("nest_level", due.level, nest_level);
					check_field("run_last", due.last, run_last);
					events_checked++;
				end
			end
			out_stall <= take_break();
		end
	end

	initial begin : stimulus
		string directed[7];
		logic [7:0] syntax[8];
		int depths[5];
		bit open_dict[$];
		int left[$];
		bit started;
		bit drained;
		int pick;
		int n;
		int k;
		directed = '{"i0e", "ie", "d1:ai-5ee", "x", "3:ab", "le", "0:"};
		syntax = '{bdec_pkg::CH_INT, bdec_pkg::CH_LIST, bdec_pkg::CH_DICT, bdec_pkg::CH_END,
			bdec_pkg::CH_COLON, bdec_pkg::CH_MINUS, bdec_pkg::CH_ZERO, bdec_pkg::CH_NINE};
		depths = '{1, 31, 32, 33, 34};
		drained = 1'b0;
		clear_parser();

		foreach (directed[i]) begin
			for (int j = 0; j < directed[i].len(); j++)
				msg_bytes.insert(msg_bytes.size(), directed[i][j]);
			send_msg(1'b0, directed[i].len());
		end

		while (real_bytes < 1400) begin
			pick = $urandom_range(99);
			if (pick < 72) begin
				// well-formed nested item built depth first
				open_dict.delete();
				left.delete();
				started = 1'b0;
				while (1) begin
					while (left.size() > 0 && left[left.size() - 1] == 0) begin
						msg_bytes.insert(msg_bytes.size(), bdec_pkg::CH_END);
						void'(open_dict.pop_back());
						void'(left.pop_back());
					end
					if (started && left.size() == 0)
						break;
					started = 1'b1;
					if (left.size() > 0) begin
						left[left.size() - 1]--;
						if (open_dict[open_dict.size() - 1])
							put_str(1'b0);
					end
					k = $urandom_range(left.size() >= 3 ? 1 : 3);
					case (k)
						0: put_int();
						1: put_str(1'b0);
						default: begin
							msg_bytes.insert(msg_bytes.size(),
								k == 2 ? bdec_pkg::CH_LIST : bdec_pkg::CH_DICT);
							open_dict.insert(open_dict.size(), k == 3);
							left.insert(left.size(), $urandom_range(3));
						end
					endcase
				end
			end else if (pick < 80) begin
				// nesting around the depth limit
				n = depths[$urandom_range(4)];
				repeat (n - 1)
					msg_bytes.insert(msg_bytes.size(), bdec_pkg::CH_LIST);
				if ($urandom_range(1)) begin
					msg_bytes.insert(msg_bytes.size(), bdec_pkg::CH_DICT);
					put_str(1'b0);
				end else begin
					msg_bytes.insert(msg_bytes.size(), bdec_pkg::CH_LIST);
				end
				put_int();
				repeat (n)
					msg_bytes.insert(msg_bytes.size(), bdec_pkg::CH_END);
			end else if (pick < 87) begin
				put_str(1'b1);
			end else begin
				repeat ($urandom_range(1, 4))
					msg_bytes.insert(msg_bytes.size(), 8'($urandom_range(255)));
			end

			n = msg_bytes.size();
			case ($urandom_range(9))
				0: begin
					k = $urandom_range(1, msg_bytes.size());
					while (msg_bytes.size() > k)
						void'(msg_bytes.pop_back());
					n = k;
				end
				1: msg_bytes[$urandom_range(msg_bytes.size() - 1)] = 8'($urandom_range(255));
				2: msg_bytes[$urandom_range(msg_bytes.size() - 1)] = syntax[$urandom_range(7)];
				3: begin
					// trailing bytes after a complete item are ignored
					repeat ($urandom_range(1, 3))
						msg_bytes.insert(msg_bytes.size(), 8'($urandom_range(255)));
				end
				default: ;
			endcase
			send_msg(!drained || $urandom_range(19) == 0, n);
			drained = 1'b1;
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() > 0 || in_valid)
			@(posedge clk);
		while (want_events.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("sent %0d bytes in %0d messages (%0d after a full drain)",
			sent_count, msg_count, drain_count);
		$display("checked %0d events: scalars, strings, containers, depth limit, all errors",
			events_checked);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("timeout with %0d events still expected", want_events.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
